// ----- rtl/json_syntax_validator_defines.svh -----
// assertion macros for the json syntax validator
`ifndef JSON_SYNTAX_VALIDATOR_DEFINES_SVH
`define JSON_SYNTAX_VALIDATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define JSV_ASSERT(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("jsv: invariant violated");
`define JSV_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsv: implication violated");
`define JSV_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsv: next-cycle check violated");
`else
`define JSV_ASSERT(name, expr)
`define JSV_IMPLY(name, ante, cons)
`define JSV_NEXT(name, ante, cons)
`endif

`endif

// ----- rtl/jsv_pkg.sv -----
package jsv_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int NEST_W    = 7;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CMP_W     = (DEPTH_W > NEST_W) ? DEPTH_W : NEST_W;
  localparam int PH_W      = 5;

  localparam logic [PH_W-1:0] PH_VALUE     = 5'd0;
  localparam logic [PH_W-1:0] PH_ARR_FIRST = 5'd1;
  localparam logic [PH_W-1:0] PH_OBJ_FIRST = 5'd2;
  localparam logic [PH_W-1:0] PH_KEY       = 5'd3;
  localparam logic [PH_W-1:0] PH_KEY_STR   = 5'd4;
  localparam logic [PH_W-1:0] PH_KEY_ESC   = 5'd5;
  localparam logic [PH_W-1:0] PH_COLON     = 5'd6;
  localparam logic [PH_W-1:0] PH_STR       = 5'd7;
  localparam logic [PH_W-1:0] PH_STR_ESC   = 5'd8;
  localparam logic [PH_W-1:0] PH_AFTER     = 5'd9;
  localparam logic [PH_W-1:0] PH_N_SIGN    = 5'd10;
  localparam logic [PH_W-1:0] PH_N_INT     = 5'd11;
  localparam logic [PH_W-1:0] PH_N_DOT     = 5'd12;
  localparam logic [PH_W-1:0] PH_N_FRAC    = 5'd13;
  localparam logic [PH_W-1:0] PH_N_EXP     = 5'd14;
  localparam logic [PH_W-1:0] PH_N_EXPSIGN = 5'd15;
  localparam logic [PH_W-1:0] PH_N_EXPDIG  = 5'd16;
  localparam logic [PH_W-1:0] PH_LIT0      = 5'd17;
  localparam logic [PH_W-1:0] PH_LIT_END   = 5'd29;

  localparam logic [3:0] LIT_T_HEAD = 4'd0;
  localparam logic [3:0] LIT_F_HEAD = 4'd4;
  localparam logic [3:0] LIT_N_HEAD = 4'd9;
  localparam logic [3:0] LIT_T_LAST = 4'd3;
  localparam logic [3:0] LIT_F_LAST = 4'd8;
  localparam logic [3:0] LIT_N_LAST = 4'd12;
  localparam logic [PH_W-1:0] PH_LIT_T = PH_LIT0 + 5'd1;
  localparam logic [PH_W-1:0] PH_LIT_F = PH_LIT0 + 5'd5;
  localparam logic [PH_W-1:0] PH_LIT_N = PH_LIT0 + 5'd10;

  localparam logic [1:0] KIND_SCALAR = 2'd0;
  localparam logic [1:0] KIND_OBJECT = 2'd1;
  localparam logic [1:0] KIND_ARRAY  = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SYNTAX  = 2'd1;
  localparam logic [1:0] ERR_NESTING = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_N   = 8'h6e;

  typedef struct packed {
    logic [PH_W-1:0]    phase;
    logic [DEPTH_W-1:0] depth;
    logic               top_arr;
    logic [1:0]         first_kind;
    logic [1:0]         err;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_bit;
  } jsv_step_t;

  function automatic logic [7:0] lit_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h74;
      4'd1:    c = 8'h72;
      4'd2:    c = 8'h75;
      4'd3:    c = 8'h65;
      4'd4:    c = 8'h66;
      4'd5:    c = 8'h61;
      4'd6:    c = 8'h6c;
      4'd7:    c = 8'h73;
      4'd8:    c = 8'h65;
      4'd9:    c = 8'h6e;
      4'd10:   c = 8'h75;
      4'd11:   c = 8'h6c;
      4'd12:   c = 8'h6c;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

// ----- rtl/jsv_stack_ram.sv -----
module jsv_stack_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic              wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              rd_data
);

  logic mem [DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/jsv_step.sv -----
module jsv_step import jsv_pkg::*; (
  input  logic [7:0]        data_byte,
  input  logic [NEST_W-1:0] max_nesting,
  input  jsv_step_t         cur,
  input  logic              below_arr,
  output jsv_step_t         nxt
);

  logic             f1;
  logic             do_start;
  logic             do_after;
  logic             do_open;
  logic             open_arr;
  logic             do_close;
  logic [3:0]       li;
  logic [CMP_W-1:0] lim;
  logic [CMP_W-1:0] cfg_e;

  assign cfg_e = CMP_W'(max_nesting);
  assign lim   = (cfg_e > CMP_W'(MAX_DEPTH)) ? CMP_W'(MAX_DEPTH) : cfg_e;
  assign li    = 4'(cur.phase - PH_LIT0);

  always_comb begin
    nxt         = cur;
    nxt.wr_en   = 1'b0;
    nxt.wr_addr = ADDR_W'(cur.depth);
    nxt.wr_bit  = 1'b0;
    f1          = 1'b0;
    do_start    = 1'b0;
    do_after    = 1'b0;
    do_open     = 1'b0;
    open_arr    = 1'b0;
    do_close    = 1'b0;
    if (cur.err == ERR_NONE) begin
      if (data_byte == CH_NUL) begin
        f1 = 1'b1;
      end else if (cur.phase >= PH_LIT0 && cur.phase <= PH_LIT_END) begin
        if (li == LIT_T_HEAD || li == LIT_F_HEAD || li == LIT_N_HEAD ||
            data_byte != lit_char(li)) begin
          f1 = 1'b1;
        end else if (li == LIT_T_LAST || li == LIT_F_LAST || li == LIT_N_LAST) begin
          nxt.phase = PH_AFTER;
        end else begin
          nxt.phase = cur.phase + 5'd1;
        end
      end else begin
        case (cur.phase)
          PH_VALUE: begin
            if (!is_blank(data_byte)) do_start = 1'b1;
          end
          PH_ARR_FIRST: begin
            if (!is_blank(data_byte)) begin
              if (data_byte == CH_RBRACK) do_close = 1'b1;
              else do_start = 1'b1;
            end
          end
          PH_OBJ_FIRST: begin
            if (!is_blank(data_byte)) begin
              if (data_byte == CH_RBRACE) do_close = 1'b1;
              else if (data_byte == CH_QUOTE) nxt.phase = PH_KEY_STR;
              else f1 = 1'b1;
            end
          end
          PH_KEY: begin
            if (!is_blank(data_byte)) begin
              if (data_byte == CH_QUOTE) nxt.phase = PH_KEY_STR;
              else f1 = 1'b1;
            end
          end
          PH_KEY_STR: begin
            if (data_byte == CH_BSLASH) nxt.phase = PH_KEY_ESC;
            else if (data_byte == CH_QUOTE) nxt.phase = PH_COLON;
          end
          PH_KEY_ESC: begin
            nxt.phase = PH_KEY_STR;
          end
          PH_COLON: begin
            if (!is_blank(data_byte)) begin
              if (data_byte == CH_COLON) nxt.phase = PH_VALUE;
              else f1 = 1'b1;
            end
          end
          PH_STR: begin
            if (data_byte == CH_BSLASH) nxt.phase = PH_STR_ESC;
            else if (data_byte == CH_QUOTE) nxt.phase = PH_AFTER;
          end
          PH_STR_ESC: begin
            nxt.phase = PH_STR;
          end
          PH_AFTER: begin
            do_after = 1'b1;
          end
          PH_N_SIGN: begin
            if (is_digit(data_byte)) nxt.phase = PH_N_INT;
            else f1 = 1'b1;
          end
          PH_N_INT: begin
            if (!is_digit(data_byte)) begin
              if (data_byte == CH_DOT) begin
                nxt.phase = PH_N_DOT;
              end else if (data_byte == CH_LO_E || data_byte == CH_UP_E) begin
                nxt.phase = PH_N_EXP;
              end else begin
                nxt.phase = PH_AFTER;
                do_after  = 1'b1;
              end
            end
          end
          PH_N_DOT: begin
            if (is_digit(data_byte)) nxt.phase = PH_N_FRAC;
            else f1 = 1'b1;
          end
          PH_N_FRAC: begin
            if (!is_digit(data_byte)) begin
              if (data_byte == CH_LO_E || data_byte == CH_UP_E) begin
                nxt.phase = PH_N_EXP;
              end else begin
                nxt.phase = PH_AFTER;
                do_after  = 1'b1;
              end
            end
          end
          PH_N_EXP: begin
            if (data_byte == CH_PLUS || data_byte == CH_MINUS) nxt.phase = PH_N_EXPSIGN;
            else if (is_digit(data_byte)) nxt.phase = PH_N_EXPDIG;
            else f1 = 1'b1;
          end
          PH_N_EXPSIGN: begin
            if (is_digit(data_byte)) nxt.phase = PH_N_EXPDIG;
            else f1 = 1'b1;
          end
          PH_N_EXPDIG: begin
            if (!is_digit(data_byte)) begin
              nxt.phase = PH_AFTER;
              do_after  = 1'b1;
            end
          end
          default: begin
            f1 = 1'b1;
          end
        endcase
      end

      if (do_start) begin
        if (cur.depth == '0) begin
          if (data_byte == CH_LBRACE) nxt.first_kind = KIND_OBJECT;
          else if (data_byte == CH_LBRACK) nxt.first_kind = KIND_ARRAY;
          else nxt.first_kind = KIND_SCALAR;
        end
        if (data_byte == CH_QUOTE) begin
          nxt.phase = PH_STR;
        end else if (data_byte == CH_LBRACE) begin
          do_open = 1'b1;
        end else if (data_byte == CH_LBRACK) begin
          do_open  = 1'b1;
          open_arr = 1'b1;
        end else if (data_byte == CH_LO_T) begin
          nxt.phase = PH_LIT_T;
        end else if (data_byte == CH_LO_F) begin
          nxt.phase = PH_LIT_F;
        end else if (data_byte == CH_LO_N) begin
          nxt.phase = PH_LIT_N;
        end else if (data_byte == CH_MINUS) begin
          nxt.phase = PH_N_SIGN;
        end else if (is_digit(data_byte)) begin
          nxt.phase = PH_N_INT;
        end else begin
          f1 = 1'b1;
        end
      end

      if (do_after && !is_blank(data_byte)) begin
        if (cur.depth == '0) begin
          f1 = 1'b1;
        end else if (data_byte == CH_COMMA) begin
          nxt.phase = cur.top_arr ? PH_VALUE : PH_KEY;
        end else if (data_byte == CH_RBRACK && cur.top_arr) begin
          do_close = 1'b1;
        end else if (data_byte == CH_RBRACE && !cur.top_arr) begin
          do_close = 1'b1;
        end else begin
          f1 = 1'b1;
        end
      end

      if (do_open) begin
        if (CMP_W'(cur.depth) >= lim) begin
          nxt.err = ERR_NESTING;
        end else begin
          nxt.wr_en   = 1'b1;
          nxt.wr_bit  = open_arr;
          nxt.depth   = cur.depth + DEPTH_W'(1);
          nxt.top_arr = open_arr;
          nxt.phase   = open_arr ? PH_ARR_FIRST : PH_OBJ_FIRST;
        end
      end

      if (do_close) begin
        nxt.depth   = cur.depth - DEPTH_W'(1);
        nxt.top_arr = below_arr;
        nxt.phase   = PH_AFTER;
      end

      if (f1) nxt.err = ERR_SYNTAX;
    end
  end

endmodule

// ----- rtl/json_syntax_validator.sv -----
// Channel | Handshake                  | Payload
// in      | in_tvalid / in_tready      | in_tdata = data_byte, in_tlast = last_byte
// out     | out_tvalid / out_tready    | out_tdata = valid_res, top_kind, error_kind
// cfg     | cfg_we                     | cfg_wdata = max_nesting
// One byte per cycle while in_tready is high; a result appears the cycle after the byte marked last.
// The stack memory is read ahead at the entry below the next top, so a
// close followed by another close still sees its kind bit in time.
// No clearing pass after reset: a bit read from a stack entry is used only after that entry was written.
// Input stalls only while a result waits in the output register and is not taken.
`include "json_syntax_validator_defines.svh"
module json_syntax_validator import jsv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic              in_tlast,   // last_byte
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [0] valid_res, [2:1] top_kind, [4:3] error_kind
  input  logic              cfg_we,
  input  logic [NEST_W-1:0] cfg_wdata
);

  jsv_step_t         st_r;
  jsv_step_t         st_nxt;
  jsv_step_t         step_out;
  logic [NEST_W-1:0] max_nest_r;
  logic              below_arr;
  logic              in_acc;
  logic              complete;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] rd_addr;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [4:0]        out_data_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  jsv_step u_step (
    .data_byte   (in_tdata),
    .max_nesting (max_nest_r),
    .cur         (st_r),
    .below_arr   (below_arr),
    .nxt         (step_out)
  );

  jsv_stack_ram #(
    .DEPTH  (MAX_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (in_acc && step_out.wr_en),
    .wr_addr (step_out.wr_addr),
    .wr_data (step_out.wr_bit),
    .rd_addr (rd_addr),
    .rd_data (below_arr)
  );

  assign complete = (step_out.depth == '0) &&
                    (step_out.phase == PH_AFTER || step_out.phase == PH_N_INT ||
                     step_out.phase == PH_N_FRAC || step_out.phase == PH_N_EXPDIG);
  assign kind = (step_out.err == ERR_NONE && !complete) ? ERR_SYNTAX : step_out.err;

  always_comb begin
    st_nxt = st_r;
    if (in_acc) begin
      st_nxt = step_out;
      if (in_tlast) begin
        st_nxt.phase      = PH_VALUE;
        st_nxt.depth      = '0;
        st_nxt.first_kind = KIND_SCALAR;
        st_nxt.err        = ERR_NONE;
      end
    end
    st_nxt.wr_en = 1'b0;
  end

  // prefetch the entry below the next top
  assign rd_addr = ADDR_W'(st_nxt.depth - DEPTH_W'(2));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (in_acc && in_tlast) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    st_r.top_arr <= st_nxt.top_arr;
    st_r.wr_addr <= st_nxt.wr_addr;
    st_r.wr_bit  <= st_nxt.wr_bit;
    if (!rst_n) begin
      st_r.phase      <= PH_VALUE;
      st_r.depth      <= '0;
      st_r.first_kind <= KIND_SCALAR;
      st_r.err        <= ERR_NONE;
      st_r.wr_en      <= 1'b0;
      max_nest_r      <= NEST_W'(MAX_DEPTH);
      out_valid_r     <= 1'b0;
    end else begin
      st_r.phase      <= st_nxt.phase;
      st_r.depth      <= st_nxt.depth;
      st_r.first_kind <= st_nxt.first_kind;
      st_r.err        <= st_nxt.err;
      st_r.wr_en      <= st_nxt.wr_en;
      out_valid_r     <= out_valid_nxt;
      if (cfg_we) max_nest_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      out_data_r <= {kind, step_out.first_kind, (kind == ERR_NONE)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r};

  `JSV_ASSERT(a_depth_bound, st_r.depth <= DEPTH_W'(MAX_DEPTH))
  `JSV_IMPLY(a_result_from_last, $rose(out_valid_r), $past(in_acc && in_tlast))
  `JSV_IMPLY(a_verdict_match, out_valid_r, out_data_r[0] == (out_data_r[4:3] == ERR_NONE))
  `JSV_NEXT(a_error_sticks, in_acc && !in_tlast && st_r.err != ERR_NONE, st_r.err == $past(st_r.err))

endmodule
